// ===== rtl/slm_pkg.sv =====
// ----------------------------------------------------------------------------
// slm_pkg
// shared sizes, codes and types of the sliding window load meter
// ----------------------------------------------------------------------------
package slm_pkg;

   // ring of interval records
   localparam int RECORD_DEPTH = 64;
   localparam int TIME_BITS    = 48;

   localparam int SLOT_BITS  = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(RECORD_DEPTH + 1);
   localparam int ENTRY_BITS = TIME_BITS + 1;

   // field and register widths
   localparam int OP_BITS     = 2;
   localparam int TS_BITS     = 48;
   localparam int PCT_BITS    = 7;
   localparam int MAXREC_BITS = 7;
   localparam int WINDOW_BITS = 48;

   // arithmetic widths
   localparam int SUM_BITS     = TIME_BITS + SLOT_BITS;
   localparam int TOTAL_BITS   = SUM_BITS + 1;
   localparam int PRODUCT_BITS = TOTAL_BITS + PCT_BITS - 1;
   localparam int STEP_BITS    = $clog2(PCT_BITS);
   localparam int LIMIT_BITS   = (COUNT_BITS > MAXREC_BITS) ? COUNT_BITS : MAXREC_BITS;
   localparam int WCMP_BITS    = (TOTAL_BITS > WINDOW_BITS) ? TOTAL_BITS : WINDOW_BITS;

   localparam int PCT_SCALE = 100;

   // configuration port
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_REG_LSB   = 3;

   localparam logic REG_MAX_RECORDS = 1'b0;
   localparam logic REG_MAX_WINDOW  = 1'b1;

   localparam logic [MAXREC_BITS-1:0] MAX_RECORDS_RESET = MAXREC_BITS'(32);
   localparam logic [WINDOW_BITS-1:0] MAX_WINDOW_RESET  = WINDOW_BITS'(1000000);

   // operations
   localparam logic [OP_BITS-1:0] OP_GO_IDLE = 2'd0;
   localparam logic [OP_BITS-1:0] OP_WAKE_UP = 2'd1;
   localparam logic [OP_BITS-1:0] OP_QUERY   = 2'd2;

   typedef struct packed {
      logic [MAXREC_BITS-1:0] max_records;
      logic [WINDOW_BITS-1:0] max_window_usec;
   } cfg_type;

endpackage

// ===== rtl/slm_req_if.sv =====
// ----------------------------------------------------------------------------
// slm_req_if
// event channel: operation and timestamp word
// ----------------------------------------------------------------------------
interface slm_req_if import slm_pkg::*; ();

   logic               valid;
   logic               ready;
   logic [OP_BITS-1:0] operation;
   logic [TS_BITS-1:0] timestamp_usec;

   modport source (output valid, output operation, output timestamp_usec, input ready);
   modport sink   (input valid, input operation, input timestamp_usec, output ready);

endinterface

// ===== rtl/slm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// slm_rsp_if
// result channel: load percentage word
// ----------------------------------------------------------------------------
interface slm_rsp_if import slm_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [PCT_BITS-1:0] load_percent;

   modport source (output valid, output load_percent, input ready);
   modport sink   (input valid, input load_percent, output ready);

endinterface

// ===== rtl/slm_ram.sv =====
// ----------------------------------------------------------------------------
// slm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module slm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic                                       re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/slm_csr.sv =====
// ----------------------------------------------------------------------------
// slm_csr
// apb-style register block: record limit and window limit
// ----------------------------------------------------------------------------
module slm_csr import slm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    reg_sel;
   logic    wr_en;

   assign reg_sel = paddr[CSR_REG_LSB];
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_MAX_RECORDS: cfg_in.max_records     = pwdata[MAXREC_BITS-1:0];
            REG_MAX_WINDOW:  cfg_in.max_window_usec = pwdata[WINDOW_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_MAX_RECORDS: prdata = CSR_DATA_BITS'(cfg_ff.max_records);
         REG_MAX_WINDOW:  prdata = CSR_DATA_BITS'(cfg_ff.max_window_usec);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_records     <= MAX_RECORDS_RESET;
         cfg_ff.max_window_usec <= MAX_WINDOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

// ===== rtl/slm_div.sv =====
// ----------------------------------------------------------------------------
// slm_div
// restoring divider, one quotient bit a cycle, for quotients below 2^PCT_BITS
// ----------------------------------------------------------------------------
module slm_div import slm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [PRODUCT_BITS-1:0] dividend,
   input  logic [TOTAL_BITS-1:0]   divisor,
   output logic                    done,
   output logic [PCT_BITS-1:0]     quotient
);

   logic                    run_ff,  run_in;
   logic                    done_ff, done_in;
   logic [STEP_BITS-1:0]    step_ff, step_in;
   logic [PRODUCT_BITS-1:0] rem_ff,  rem_in;
   logic [PRODUCT_BITS-1:0] den_ff,  den_in;
   logic [PCT_BITS-1:0]     quo_ff,  quo_in;
   logic                    fits;

   assign fits = (rem_ff >= den_ff);

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = STEP_BITS'(PCT_BITS - 1);
         rem_in  = dividend;
         den_in  = PRODUCT_BITS'(divisor) << (PCT_BITS - 1);
         quo_in  = '0;
      end else if (run_ff) begin
         if (fits) begin
            rem_in = rem_ff - den_ff;
         end
         quo_in = {quo_ff[PCT_BITS-2:0], fits};
         den_in = den_ff >> 1;
         if (step_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/sliding_window_load_meter.sv =====
// ----------------------------------------------------------------------------
// sliding_window_load_meter
// busy/idle load meter over a ring of interval records
// ----------------------------------------------------------------------------
// usage
//   req_chan carries one event word: operation (go idle, wake up, query) and a
//   free running microsecond timestamp. go idle and wake up close the open
//   interval and append its length to a ring held in one ram; a query evicts
//   old records beyond the window or record limit and answers busy*100/total
//   as one word on rsp_chan. operation code 3 is dropped without effect.
//   the block works on one event at a time: req_chan.ready is high only when
//   the sequencer is idle. go idle and wake up read the oldest record from
//   the ram when it must be dropped; a zero record limit discards the
//   interval at once. a query reads each evicted record from the ram and
//   skips the division when the total is zero; the division produces one
//   bit a cycle. the result sits in an output register; events keep being
//   accepted while it waits for rsp_chan.ready. a following query holds in
//   its last state until that register is free. reset (synchronous) empties
//   the ring, marks the meter busy since time zero and loads a 32 record,
//   1 s window limit. the ram needs no clearing pass: only written entries
//   are ever read. the user must write the limits on the csr_ apb port only
//   while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sliding_window_load_meter import slm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   slm_req_if.sink                  req_chan,
   slm_rsp_if.source                rsp_chan,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   // sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_APPEND  = 4'd1;   // decide whether a drop is needed
   localparam logic [3:0] S_DROP    = 4'd2;   // oldest record arrives from ram
   localparam logic [3:0] S_WRITE   = 4'd3;   // store the closed interval
   localparam logic [3:0] S_QSUM    = 4'd4;   // total = busy + idle + open
   localparam logic [3:0] S_QCHECK  = 4'd5;   // evict test, ram read of oldest
   localparam logic [3:0] S_QREAD   = 4'd6;   // evicted record arrives
   localparam logic [3:0] S_MUL     = 4'd7;
   localparam logic [3:0] S_DIVGO   = 4'd8;
   localparam logic [3:0] S_DIVWAIT = 4'd9;
   localparam logic [3:0] S_OUT     = 4'd10;

   cfg_type cfg;

   logic [3:0]              state_ff,      state_in;
   logic [SLOT_BITS-1:0]    oldest_ff,     oldest_in;
   logic [COUNT_BITS-1:0]   count_ff,      count_in;
   logic [SUM_BITS-1:0]     busy_sum_ff,   busy_sum_in;
   logic [SUM_BITS-1:0]     idle_sum_ff,   idle_sum_in;
   logic                    is_idle_ff,    is_idle_in;
   logic [TIME_BITS-1:0]    idle_since_ff, idle_since_in;
   logic [TIME_BITS-1:0]    busy_since_ff, busy_since_in;
   logic [TIME_BITS-1:0]    len_ff,        len_in;
   logic                    len_idle_ff,   len_idle_in;
   logic [TOTAL_BITS-1:0]   total_ff,      total_in;
   logic [PRODUCT_BITS-1:0] product_ff,    product_in;
   logic [PCT_BITS-1:0]     pct_ff,        pct_in;
   logic                    rsp_valid_ff,  rsp_valid_in;
   logic [PCT_BITS-1:0]     load_ff,       load_in;

   logic                    req_fire;
   logic [TIME_BITS-1:0]    now;
   logic [LIMIT_BITS-1:0]   maxrec_ext;
   logic [LIMIT_BITS-1:0]   limit;
   logic [LIMIT_BITS-1:0]   count_ext;
   logic                    over_limit;
   logic                    over_window;
   logic [SLOT_BITS:0]      slot_sum;
   logic [SLOT_BITS-1:0]    wr_slot;
   logic [SLOT_BITS-1:0]    oldest_next;

   // ring memory: {was idle, length}
   logic                    ram_we;
   logic                    ram_re;
   logic [ENTRY_BITS-1:0]   ram_wdata;
   logic [ENTRY_BITS-1:0]   ram_rdata;
   logic [TIME_BITS-1:0]    rd_len;
   logic                    rd_idle;

   logic                    div_start;
   logic                    div_done;
   logic [PCT_BITS-1:0]     div_quo;

   slm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   slm_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (RECORD_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (wr_slot),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (oldest_ff),
      .rdata (ram_rdata)
   );

   slm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product_ff),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_fire = req_chan.valid && req_chan.ready;
   assign now      = TIME_BITS'(req_chan.timestamp_usec);

   // effective record limit never exceeds the ring depth
   assign maxrec_ext = LIMIT_BITS'(cfg.max_records);
   assign limit      = (maxrec_ext > LIMIT_BITS'(RECORD_DEPTH)) ?
                       LIMIT_BITS'(RECORD_DEPTH) : maxrec_ext;
   assign count_ext  = LIMIT_BITS'(count_ff);
   assign over_limit = (count_ext > limit);
   assign over_window = (WCMP_BITS'(total_ff) > WCMP_BITS'(cfg.max_window_usec));

   // slot arithmetic modulo the ring depth
   assign slot_sum    = (SLOT_BITS+1)'(oldest_ff) + (SLOT_BITS+1)'(count_ff);
   assign wr_slot     = (slot_sum >= (SLOT_BITS+1)'(RECORD_DEPTH)) ?
                        SLOT_BITS'(slot_sum - (SLOT_BITS+1)'(RECORD_DEPTH)) :
                        SLOT_BITS'(slot_sum);
   assign oldest_next = (oldest_ff == SLOT_BITS'(RECORD_DEPTH - 1)) ?
                        '0 : oldest_ff + 1'b1;

   assign rd_len  = ram_rdata[TIME_BITS-1:0];
   assign rd_idle = ram_rdata[TIME_BITS];

   assign ram_wdata = {len_idle_ff, len_ff};

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.load_percent = load_ff;

   always_comb begin
      state_in      = state_ff;
      oldest_in     = oldest_ff;
      count_in      = count_ff;
      busy_sum_in   = busy_sum_ff;
      idle_sum_in   = idle_sum_ff;
      is_idle_in    = is_idle_ff;
      idle_since_in = idle_since_ff;
      busy_since_in = busy_since_ff;
      len_in        = len_ff;
      len_idle_in   = len_idle_ff;
      total_in      = total_ff;
      product_in    = product_ff;
      pct_in        = pct_ff;
      load_in       = load_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      div_start     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_chan.operation)
                  OP_GO_IDLE: begin
                     // closes a busy interval
                     len_in        = now - busy_since_ff;
                     len_idle_in   = 1'b0;
                     is_idle_in    = 1'b1;
                     idle_since_in = now;
                     state_in      = S_APPEND;
                  end
                  OP_WAKE_UP: begin
                     // closes an idle interval
                     len_in        = now - idle_since_ff;
                     len_idle_in   = 1'b1;
                     is_idle_in    = 1'b0;
                     busy_since_in = now;
                     state_in      = S_APPEND;
                  end
                  OP_QUERY: begin
                     // open interval length, counted in the total only
                     len_in   = now - (is_idle_ff ? idle_since_ff : busy_since_ff);
                     state_in = S_QSUM;
                  end
                  default: ;
               endcase
            end
         end

         S_APPEND: begin
            if (count_ext >= limit) begin
               if (count_ff == '0) begin
                  // zero limit: recorded and dropped at once
                  state_in = S_IDLE;
               end else begin
                  ram_re   = 1'b1;
                  state_in = S_DROP;
               end
            end else begin
               state_in = S_WRITE;
            end
         end

         S_DROP: begin
            if (rd_idle) begin
               idle_sum_in = idle_sum_ff - SUM_BITS'(rd_len);
            end else begin
               busy_sum_in = busy_sum_ff - SUM_BITS'(rd_len);
            end
            oldest_in = oldest_next;
            count_in  = count_ff - 1'b1;
            state_in  = S_WRITE;
         end

         S_WRITE: begin
            ram_we   = 1'b1;
            count_in = count_ff + 1'b1;
            if (len_idle_ff) begin
               idle_sum_in = idle_sum_ff + SUM_BITS'(len_ff);
            end else begin
               busy_sum_in = busy_sum_ff + SUM_BITS'(len_ff);
            end
            state_in = S_IDLE;
         end

         S_QSUM: begin
            total_in = TOTAL_BITS'(busy_sum_ff) + TOTAL_BITS'(idle_sum_ff) +
                       TOTAL_BITS'(len_ff);
            state_in = S_QCHECK;
         end

         S_QCHECK: begin
            if ((count_ff != '0) && (over_window || over_limit)) begin
               ram_re   = 1'b1;
               state_in = S_QREAD;
            end else begin
               state_in = S_MUL;
            end
         end

         S_QREAD: begin
            total_in = total_ff - TOTAL_BITS'(rd_len);
            if (rd_idle) begin
               idle_sum_in = idle_sum_ff - SUM_BITS'(rd_len);
            end else begin
               busy_sum_in = busy_sum_ff - SUM_BITS'(rd_len);
            end
            oldest_in = oldest_next;
            count_in  = count_ff - 1'b1;
            state_in  = S_QCHECK;
         end

         S_MUL: begin
            product_in = PRODUCT_BITS'(busy_sum_ff) * PRODUCT_BITS'(PCT_SCALE);
            state_in   = S_DIVGO;
         end

         S_DIVGO: begin
            if (total_ff == '0) begin
               pct_in   = '0;
               state_in = S_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIVWAIT;
            end
         end

         S_DIVWAIT: begin
            if (div_done) begin
               pct_in   = (div_quo > PCT_BITS'(PCT_SCALE)) ? PCT_BITS'(PCT_SCALE) : div_quo;
               state_in = S_OUT;
            end
         end

         S_OUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               load_in      = pct_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         oldest_ff     <= '0;
         count_ff      <= '0;
         busy_sum_ff   <= '0;
         idle_sum_ff   <= '0;
         is_idle_ff    <= 1'b0;
         idle_since_ff <= '0;
         busy_since_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         oldest_ff     <= oldest_in;
         count_ff      <= count_in;
         busy_sum_ff   <= busy_sum_in;
         idle_sum_ff   <= idle_sum_in;
         is_idle_ff    <= is_idle_in;
         idle_since_ff <= idle_since_in;
         busy_since_ff <= busy_since_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      len_ff      <= len_in;
      len_idle_ff <= len_idle_in;
      total_ff    <= total_in;
      product_ff  <= product_in;
      pct_ff      <= pct_in;
      load_ff     <= load_in;
   end

endmodule

// ===== dv/slm_load_checker.sv =====
// ----------------------------------------------------------------------------
// slm_load_checker
// watches the event, result and csr ports of the load meter, keeps its own
// ring of busy and idle intervals and checks every load word in order
// ----------------------------------------------------------------------------
module slm_load_checker import slm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   slm_req_if                       req_chan,
   slm_rsp_if                       rsp_chan,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic                     csr_pready,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output int                       mismatch_count,
   output int                       pending_results,
   output int                       reports_checked,
   output int                       deepest_eviction
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   // ring of closed intervals
   logic [TIME_BITS-1:0] span_length [RECORD_DEPTH];
   logic                 span_idle   [RECORD_DEPTH];
   int unsigned          head_slot;
   int unsigned          span_count;
   logic [63:0]          busy_total;
   logic [63:0]          idle_total;
   logic                 meter_idle;
   logic [TIME_BITS-1:0] idle_start;
   logic [TIME_BITS-1:0] busy_start;
   cfg_type              limits;

   logic [PCT_BITS-1:0]  load_expect_q [$];
   logic [PCT_BITS-1:0]  load_want;
   int                   errors;
   int                   checked;
   int                   evict_peak;

   function automatic void clear_meter();
      head_slot   = 0;
      span_count  = 0;
      busy_total  = '0;
      idle_total  = '0;
      meter_idle  = 1'b0;
      idle_start  = '0;
      busy_start  = '0;
      limits.max_records     = MAX_RECORDS_RESET;
      limits.max_window_usec = MAX_WINDOW_RESET;
   endfunction

   function automatic int unsigned record_cap();
      if (int'(limits.max_records) > RECORD_DEPTH)
         return RECORD_DEPTH;
      return int'(limits.max_records);
   endfunction

   function automatic void retire_oldest();
      if (span_idle[head_slot])
         idle_total -= 64'(span_length[head_slot]);
      else
         busy_total -= 64'(span_length[head_slot]);
      head_slot  = (head_slot + 1) % RECORD_DEPTH;
      span_count = span_count - 1;
   endfunction

   function automatic void store_interval(input logic [TIME_BITS-1:0] len,
                                          input logic was_idle);
      int unsigned slot;
      if (span_count + 1 > record_cap()) begin
         // zero limit: recorded and dropped at once
         if (span_count == 0)
            return;
         retire_oldest();
      end
      slot = (head_slot + span_count) % RECORD_DEPTH;
      span_length[slot] = len;
      span_idle[slot]   = was_idle;
      span_count        = span_count + 1;
      if (was_idle)
         idle_total += 64'(len);
      else
         busy_total += 64'(len);
   endfunction

   // open interval counts in the total only
   function automatic logic [PCT_BITS-1:0] measure_load(input logic [TIME_BITS-1:0] now);
      logic [TIME_BITS-1:0] open_span;
      logic [63:0]          span_total;
      logic [63:0]          share;
      int                   dropped;
      open_span  = now - (meter_idle ? idle_start : busy_start);
      span_total = busy_total + idle_total + 64'(open_span);
      share      = '0;
      dropped    = 0;
      while (span_count > 0 &&
             (span_total > 64'(limits.max_window_usec) || span_count > record_cap())) begin
         span_total -= 64'(span_length[head_slot]);
         retire_oldest();
         dropped++;
      end
      if (dropped > evict_peak)
         evict_peak = dropped;
      if (span_total != 0) begin
         share = (busy_total * 64'(PCT_SCALE)) / span_total;
         if (share > 64'(PCT_SCALE))
            share = 64'(PCT_SCALE);
      end
      return share[PCT_BITS-1:0];
   endfunction

   function automatic void apply_event(input logic [OP_BITS-1:0] op,
                                       input logic [TIME_BITS-1:0] now);
      logic [TIME_BITS-1:0] len;
      case (op)
         OP_GO_IDLE: begin
            len        = now - busy_start;
            meter_idle = 1'b1;
            idle_start = now;
            store_interval(len, 1'b0);
         end
         OP_WAKE_UP: begin
            len        = now - idle_start;
            meter_idle = 1'b0;
            busy_start = now;
            store_interval(len, 1'b1);
         end
         OP_QUERY: load_expect_q.push_back(measure_load(now));
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_meter();
         load_expect_q.delete();
      end else begin
         // older load word is checked before a new query is predicted
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (load_expect_q.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("[%0t] load word %0d with no query waiting",
                           $time, rsp_chan.load_percent);
            end else begin
               load_want = load_expect_q[0];
               load_expect_q.delete(0);
               checked++;
               if (rsp_chan.load_percent !== load_want) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("[%0t] load word %0d: expected %0d, got %0d",
                              $time, checked, load_want, rsp_chan.load_percent);
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            apply_event(req_chan.operation, req_chan.timestamp_usec);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[CSR_ADDR_BITS-1:CSR_REG_LSB] == REG_MAX_RECORDS)
               limits.max_records = csr_pwdata[MAXREC_BITS-1:0];
            else if (csr_paddr[CSR_ADDR_BITS-1:CSR_REG_LSB] == REG_MAX_WINDOW)
               limits.max_window_usec = csr_pwdata[WINDOW_BITS-1:0];
         end
      end
      mismatch_count   <= errors;
      pending_results  <= load_expect_q.size();
      reports_checked  <= checked;
      deepest_eviction <= evict_peak;
   end

endmodule

// ===== dv/tb_sliding_window_load_meter.sv =====
// ----------------------------------------------------------------------------
// tb_sliding_window_load_meter
// drives busy/idle/query event words into the load meter under changing
// record and window limits, with random idling on both channels; the load
// checker beside the block predicts and compares every load word
// ----------------------------------------------------------------------------
module tb_sliding_window_load_meter;
   import slm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF    = 10;
   localparam int RESET_CYCLES  = 10;
   // slowest legal run: every query evicting a full ring, plus gaps and
   // stalls, long hold-offs and settles: this limit leaves a wide margin
   localparam int CYCLE_LIMIT   = 500000;
   // long enough for the last go idle or wake up to finish after acceptance
   localparam int SETTLE_CYCLES = 16;
   localparam int LONG_HOLD     = 400;

   localparam logic [OP_BITS-1:0]     OP_UNUSED  = 2'd3;
   localparam logic [TS_BITS-1:0]     STAMP_MAX  = '1;
   localparam logic [WINDOW_BITS-1:0] WINDOW_ALL = '1;

   // how far apart consecutive timestamps land
   typedef enum {PACE_TINY, PACE_MID, PACE_WIDE} pace_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   slm_req_if req_chan ();
   slm_rsp_if rsp_chan ();

   int mismatch_count;
   int pending_results;
   int reports_checked;
   int deepest_eviction;

   // stimulus bookkeeping
   logic [TS_BITS-1:0] now_usec;
   logic               meter_idle;
   int                 events_sent;
   int                 limit_settings;
   bit                 quiet;
   bit                 burst;
   int                 hold_requests;
   int                 holds_done;

   sliding_window_load_meter uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   slm_load_checker load_check (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_pready       (csr_pready),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .mismatch_count   (mismatch_count),
      .pending_results  (pending_results),
      .reports_checked  (reports_checked),
      .deepest_eviction (deepest_eviction)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // next timestamp; a rare far jump keeps the high bits moving and wraps
   function automatic logic [TS_BITS-1:0] stamp_after(input pace_type pace);
      logic [TS_BITS-1:0] delta;
      case (pace)
         PACE_TINY: delta = TS_BITS'($urandom_range(0, 40));
         PACE_MID:  delta = TS_BITS'($urandom_range(0, 30000));
         default:   delta = TS_BITS'({$urandom, $urandom});
      endcase
      if (pace != PACE_WIDE && $urandom_range(0, 63) == 0)
         delta = TS_BITS'({$urandom, $urandom});
      return now_usec + delta;
   endfunction

   // one event word; valid stays high into the next word unless a gap follows
   task automatic send_event(input logic [OP_BITS-1:0] op, input logic [TS_BITS-1:0] stamp);
      int gap;
      if (!quiet && !burst && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.operation      <= op;
      req_chan.timestamp_usec <= stamp;
      do @(posedge clock); while (!req_chan.ready);
      now_usec = stamp;
      if (op == OP_GO_IDLE)
         meter_idle = 1'b1;
      else if (op == OP_WAKE_UP)
         meter_idle = 1'b0;
      if (op != OP_UNUSED)
         events_sent++;
   endtask

   // mostly proper busy/idle alternation with queries mixed in; a few
   // repeated transitions and unused codes as noise
   task automatic random_events(input int count, input pace_type pace);
      int                 sent;
      int                 pick;
      logic [OP_BITS-1:0] op;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 4)
            op = OP_UNUSED;
         else if (pick < 9)
            op = meter_idle ? OP_GO_IDLE : OP_WAKE_UP;
         else if (pick < 40)
            op = OP_QUERY;
         else
            op = meter_idle ? OP_WAKE_UP : OP_GO_IDLE;
         send_event(op, stamp_after(pace));
         if (op != OP_UNUSED)
            sent++;
      end
   endtask

   // drop valid and wait for every load word, then for the tail of the
   // last go idle / wake up
   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup then access; bits above the register width carry junk
   task automatic csr_write(input logic reg_sel, input logic [CSR_DATA_BITS-1:0] value,
                            input int field_bits);
      logic [CSR_DATA_BITS-1:0] keep;
      keep = (CSR_DATA_BITS'(1) << field_bits) - 1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'(reg_sel) << CSR_REG_LSB;
      csr_pwdata  <= (CSR_DATA_BITS'({$urandom, $urandom}) & ~keep) | (value & keep);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // limits change only with the meter idle
   task automatic set_limits(input logic [MAXREC_BITS-1:0] records,
                             input logic [WINDOW_BITS-1:0] window);
      settle();
      csr_write(REG_MAX_RECORDS, CSR_DATA_BITS'(records), MAXREC_BITS);
      csr_write(REG_MAX_WINDOW, CSR_DATA_BITS'(window), WINDOW_BITS);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      limit_settings++;
   endtask

   // receiver: random ready, random stall bursts, and the long hold-off
   initial begin : rsp_pacing
      int span;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_requests != holds_done) begin
            // result register fills, next query parks and event words stall
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            holds_done++;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            span = $urandom_range(1, 10);
            rsp_chan.ready <= 1'b0;
            repeat (span) @(posedge clock);
         end else begin
            span = $urandom_range(1, 24);
            rsp_chan.ready <= 1'b1;
            repeat (span) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.operation      <= OP_GO_IDLE;
      req_chan.timestamp_usec <= '0;
      csr_psel                <= 1'b0;
      csr_penable             <= 1'b0;
      csr_pwrite              <= 1'b0;
      csr_paddr               <= '0;
      csr_pwdata              <= '0;
      now_usec       = '0;
      meter_idle     = 1'b0;
      events_sent    = 0;
      limit_settings = 0;
      quiet          = 1'b0;
      burst          = 1'b0;
      hold_requests  = 0;
      holds_done     = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under the reset limits (32 records, 1 s)
      send_event(OP_QUERY, '0);                          // empty window, zero total
      send_event(OP_QUERY, STAMP_MAX);                   // open interval only
      send_event(OP_UNUSED, STAMP_MAX);                  // ignored code
      send_event(OP_GO_IDLE, TS_BITS'(100));
      send_event(OP_GO_IDLE, TS_BITS'(250));             // repeated go idle
      send_event(OP_QUERY, TS_BITS'(300));
      send_event(OP_WAKE_UP, TS_BITS'(400));
      send_event(OP_WAKE_UP, TS_BITS'(1000));            // repeated wake up
      send_event(OP_QUERY, TS_BITS'(1000));              // open interval of zero
      send_event(OP_GO_IDLE, TS_BITS'(1500));
      send_event(OP_QUERY, TS_BITS'(1500));
      send_event(OP_WAKE_UP, STAMP_MAX - TS_BITS'(5));   // huge idle interval
      send_event(OP_QUERY, STAMP_MAX - TS_BITS'(5));     // window evicts it all
      send_event(OP_GO_IDLE, TS_BITS'(20));              // busy across the wrap
      send_event(OP_QUERY, TS_BITS'(20));                // all busy
      send_event(OP_WAKE_UP, TS_BITS'(20));              // zero length idle
      send_event(OP_QUERY, TS_BITS'(2000000));           // open beyond the window
      send_event(OP_UNUSED, '0);
      send_event(OP_QUERY, TS_BITS'(2000000));

      // full ring, no window pressure
      set_limits(MAXREC_BITS'(RECORD_DEPTH), WINDOW_ALL);
      random_events(90, PACE_TINY);

      // receiver holds off while words keep coming back to back
      burst = 1'b1;
      hold_requests = hold_requests + 1;
      random_events(40, PACE_TINY);
      burst = 1'b0;

      // limit lowered below the current count
      set_limits(MAXREC_BITS'(8), WINDOW_ALL);
      random_events(30, PACE_TINY);

      // smallest nonzero limits
      set_limits(MAXREC_BITS'(1), WINDOW_BITS'(1));
      random_events(40, PACE_MID);

      // zero limits: nothing is kept
      set_limits('0, '0);
      random_events(30, PACE_MID);

      // record limit above the ring depth, window bites
      set_limits('1, WINDOW_BITS'(50000));
      random_events(60, PACE_MID);

      // wide jumps and wraps under a random window
      set_limits(MAXREC_BITS'(100), WINDOW_BITS'({$urandom, $urandom}));
      random_events(40, PACE_WIDE);

      // back to the reset values after a full drain
      set_limits(MAX_RECORDS_RESET, MAX_WINDOW_RESET);
      random_events(40, PACE_MID);

      // last stretch with no idling on either side
      set_limits(MAXREC_BITS'(20), WINDOW_BITS'(300));
      quiet = 1'b1;
      random_events(60, PACE_TINY);

      settle();
      $display("covered %0d events and %0d load words across %0d limit settings",
               events_sent, reports_checked, limit_settings + 1);
      $display("deepest eviction in one query: %0d records", deepest_eviction);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
